### sv/mtbs_pkg.sv
// shared constants and word functions for the mt19937 bit stream matcher
package mtbs_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned ADDR_W = 10;
    localparam int unsigned BYTE_W = 8;

    localparam logic [ADDR_W:0] TW_N = 11'd624;
    localparam logic [ADDR_W-1:0] TW_M = 10'd397;
    localparam logic [ADDR_W-1:0] TW_LAST = 10'd623;

    localparam logic [WORD_W-1:0] TW_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TW_UPPER = 32'h8000_0000;
    localparam logic [WORD_W-1:0] TW_LOWER = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] TW_INIT_MUL = 32'd1812433253;
    localparam logic [WORD_W-1:0] TW_DEFAULT_SEED = 32'd5489;

    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;

    function automatic logic [ADDR_W-1:0] addr_add(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] offset
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= TW_N)
        begin
            sum = sum - TW_N;
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = (cur & TW_UPPER) | (nxt & TW_LOWER);
        v = far ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ TW_MATRIX;
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [WORD_W-1:0] init_word(
        input logic [WORD_W-1:0] prev,
        input logic [ADDR_W-1:0] k
    );
        logic [WORD_W-1:0] mix;
        logic [WORD_W-1:0] prod;
        mix = prev ^ {30'd0, prev[31:30]};
        prod = mix * TW_INIT_MUL;
        return prod + {{(WORD_W-ADDR_W){1'b0}}, k};
    endfunction

endpackage

### sv/mt19937_bit_stream_matcher.sv
// top level of the mt19937 bit stream matcher
//
// command channel: command, seed_value, target_byte, final_byte under
// cmd_valid / cmd_stall. command 0 reseeds, command 1 asks for one byte.
// result channel: generated_byte, byte_matches, all_matched under
// res_valid / res_stall, one beat per byte command, none for a reseed.
// a byte command draws 8 twister words after its beat is taken, one word
// per cycle: each word is twisted in place as it is drawn, with the next
// word and the word 397 places on read from the two ports of the state
// memory, and the byte is loaded into the output register at the last
// draw if that register is free. the next beat is taken in the idle cycle
// after that, so no new command is taken while a byte is drawn.
// a reseed runs the seed recurrence through the memory one word per cycle,
// over every word, with cmd_stall high.
// after reset the same fill loads the state for seed 5489 before
// the first command is taken.
// while res_stall holds a result, the next byte is computed and then waits
// in the core until the output register frees up; cmd_stall stays high
// whenever the core is busy or holding a byte.
module mt19937_bit_stream_matcher
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic                               command,
    input  logic [31:0]                        seed_value,
    input  logic [mtbs_pkg::BYTE_W-1:0]        target_byte,
    input  logic                               final_byte,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [mtbs_pkg::BYTE_W-1:0]        generated_byte,
    output logic                               byte_matches,
    output logic                               all_matched
);

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_BYTE = 1'b1;
    localparam logic [2:0] LAST_DRAW = 3'd7;

    typedef enum logic [1:0]
    {
        ST_SEED,
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                              state_reg, state_next;
    logic [mtbs_pkg::ADDR_W-1:0]         cnt_reg, cnt_next;
    logic [mtbs_pkg::ADDR_W-1:0]         pos_reg, pos_next;
    logic [2:0]                          draw_reg, draw_next;
    logic [mtbs_pkg::WORD_W-1:0]         cur_reg, cur_next;
    logic [mtbs_pkg::WORD_W-1:0]         prev_reg, prev_next;
    logic [mtbs_pkg::BYTE_W-1:0]         acc_reg, acc_next;
    logic [mtbs_pkg::BYTE_W-1:0]         target_reg, target_next;
    logic                                final_reg, final_next;
    logic                                match_reg, match_next;
    logic                                res_valid_reg, res_valid_next;
    logic [mtbs_pkg::BYTE_W-1:0]         gen_reg, gen_next;
    logic                                hit_reg, hit_next;
    logic                                all_reg, all_next;

    logic                                cmd_accept;
    logic                                res_accept;
    logic                                out_free;
    logic [mtbs_pkg::ADDR_W-1:0]         pos_inc;
    logic [mtbs_pkg::ADDR_W-1:0]         rd_base;
    logic [mtbs_pkg::ADDR_W-1:0]         rd_addr_a;
    logic [mtbs_pkg::ADDR_W-1:0]         rd_addr_b;
    logic [mtbs_pkg::WORD_W-1:0]         rd_data_a;
    logic [mtbs_pkg::WORD_W-1:0]         rd_data_b;
    logic [mtbs_pkg::WORD_W-1:0]         twisted;
    logic [mtbs_pkg::WORD_W-1:0]         tempered;
    logic [mtbs_pkg::WORD_W-1:0]         seed_word;
    logic [mtbs_pkg::BYTE_W-1:0]         byte_full;
    logic [mtbs_pkg::BYTE_W-1:0]         load_byte;
    logic                                load_hit;
    logic                                load_match;
    logic                                wr_en;
    logic [mtbs_pkg::ADDR_W-1:0]         wr_addr;
    logic [mtbs_pkg::WORD_W-1:0]         wr_data;

    mtbs_word_ram u_word_ram
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign cmd_stall      = (state_reg != ST_IDLE);
    assign cmd_accept     = cmd_valid && !cmd_stall;
    assign res_valid      = res_valid_reg;
    assign res_accept     = res_valid_reg && !res_stall;
    assign out_free       = !res_valid_reg || !res_stall;
    assign generated_byte = gen_reg;
    assign byte_matches   = hit_reg;
    assign all_matched    = all_reg;

    assign pos_inc   = (pos_reg == mtbs_pkg::TW_LAST) ? '0 : pos_reg + 1'b1;
    assign rd_base   = (state_reg == ST_RUN) ? pos_inc : pos_reg;
    assign rd_addr_a = mtbs_pkg::addr_add(rd_base, 10'd1);
    assign rd_addr_b = mtbs_pkg::addr_add(rd_base, mtbs_pkg::TW_M);

    assign twisted   = mtbs_pkg::twist_word(cur_reg, rd_data_a, rd_data_b);
    assign tempered  = mtbs_pkg::temper(twisted);
    assign byte_full = {acc_reg[mtbs_pkg::BYTE_W-2:0], tempered[0]};
    assign seed_word = (cnt_reg == '0) ? prev_reg
                                       : mtbs_pkg::init_word(prev_reg, cnt_reg);

    assign load_byte  = (state_reg == ST_HOLD) ? acc_reg : byte_full;
    assign load_hit   = (load_byte == target_reg);
    assign load_match = match_reg & load_hit;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = twisted;
        case (state_reg)
            ST_SEED:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = seed_word;
            end
            ST_RUN:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        draw_next      = draw_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        acc_next       = acc_reg;
        target_next    = target_reg;
        final_next     = final_reg;
        match_next     = match_reg;
        res_valid_next = res_valid_reg && !res_accept;
        gen_next       = gen_reg;
        hit_next       = hit_reg;
        all_next       = all_reg;
        case (state_reg)
            ST_SEED:
            begin
                prev_next = seed_word;
                if (cnt_reg == '0)
                begin
                    cur_next = prev_reg;
                end
                if (cnt_reg == mtbs_pkg::TW_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    if (command == CMD_SEED)
                    begin
                        prev_next  = seed_value;
                        cnt_next   = '0;
                        pos_next   = '0;
                        match_next = 1'b1;
                        state_next = ST_SEED;
                    end
                    else if (command == CMD_BYTE)
                    begin
                        target_next = target_byte;
                        final_next  = final_byte;
                        draw_next   = '0;
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                acc_next  = byte_full;
                cur_next  = rd_data_a;
                pos_next  = pos_inc;
                draw_next = draw_reg + 1'b1;
                if (draw_reg == LAST_DRAW)
                begin
                    if (out_free)
                    begin
                        match_next     = load_match;
                        res_valid_next = 1'b1;
                        gen_next       = load_byte;
                        hit_next       = load_hit;
                        all_next       = final_reg & load_match;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    match_next     = load_match;
                    res_valid_next = 1'b1;
                    gen_next       = load_byte;
                    hit_next       = load_hit;
                    all_next       = final_reg & load_match;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEED;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            draw_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= mtbs_pkg::TW_DEFAULT_SEED;
            acc_reg       <= '0;
            target_reg    <= '0;
            final_reg     <= 1'b0;
            match_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
            gen_reg       <= '0;
            hit_reg       <= 1'b0;
            all_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            draw_reg      <= draw_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            acc_reg       <= acc_next;
            target_reg    <= target_next;
            final_reg     <= final_next;
            match_reg     <= match_next;
            res_valid_reg <= res_valid_next;
            gen_reg       <= gen_next;
            hit_reg       <= hit_next;
            all_reg       <= all_next;
        end
    end

`ifndef SYNTHESIS
    // draw position always names a real word
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= mtbs_pkg::TW_LAST)
        else $error("word position out of range");

    // a fill always hands over at word zero
    a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED && cnt_reg == mtbs_pkg::TW_LAST) |=>
        (state_reg == ST_IDLE && pos_reg == '0))
        else $error("fill did not end at word zero");

    // eight draws run back to back
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && draw_reg != LAST_DRAW) |=> state_reg == ST_RUN)
        else $error("draw sequence broken");

    // a result beat only comes out of a finished byte
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(state_reg) == ST_RUN || $past(state_reg) == ST_HOLD))
        else $error("result beat without a byte");

    // a held byte never overwrites an untaken result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> ($stable(generated_byte) && res_valid))
        else $error("result overwritten while stalled");
`endif

endmodule

### sv/mtbs_word_ram.sv
// twister state memory, one write port and two registered read ports
module mtbs_word_ram
(
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [mtbs_pkg::ADDR_W-1:0]      wr_addr,
    input  logic [mtbs_pkg::WORD_W-1:0]      wr_data,
    input  logic [mtbs_pkg::ADDR_W-1:0]      rd_addr_a,
    input  logic [mtbs_pkg::ADDR_W-1:0]      rd_addr_b,
    output logic [mtbs_pkg::WORD_W-1:0]      rd_data_a,
    output logic [mtbs_pkg::WORD_W-1:0]      rd_data_b
);

    logic [mtbs_pkg::WORD_W-1:0] mem [0:mtbs_pkg::TW_N-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### tb/mtbs_tb_pkg.sv
`timescale 1ns / 100ps
// command codes shared by the mt19937 bit stream matcher testbench files
package mtbs_tb_pkg;

    typedef enum logic
    {
        CMD_RESEED    = 1'b0,
        CMD_NEXT_BYTE = 1'b1
    } mtbs_cmd_t;

endpackage

### tb/mtbs_checker.sv
`timescale 1ns / 100ps
// checker: predicts the mt19937 low-bit bytes and compares every result beat
module mtbs_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic                        cmd_stall,
    input  logic                        command,
    input  logic [31:0]                 seed_value,
    input  logic [mtbs_pkg::BYTE_W-1:0] target_byte,
    input  logic                        final_byte,
    input  logic                        res_valid,
    input  logic                        res_stall,
    input  logic [mtbs_pkg::BYTE_W-1:0] generated_byte,
    input  logic                        byte_matches,
    input  logic                        all_matched,
    output logic [mtbs_pkg::BYTE_W-1:0] coming_byte,
    output int                          awaiting,
    output int                          fail_count
);

    localparam int unsigned BYTE_W = mtbs_pkg::BYTE_W;
    localparam int DEPTH = int'(mtbs_pkg::TW_N);
    localparam int FAR = int'(mtbs_pkg::TW_M);

    typedef struct packed
    {
        logic [BYTE_W-1:0] gen;
        logic              hit;
        logic              run_hit;
    } byte_verdict_t;

    logic [31:0]   words [0:DEPTH-1];
    int unsigned   word_idx;
    logic          still_matched;
    int            errs;
    byte_verdict_t bytes_due [$];

    function automatic void seed_words(input logic [31:0] s);
        logic [31:0] p;
        words[0] = s;
        for (int k = 1; k < DEPTH; k++)
        begin
            p = words[k-1];
            words[k] = mtbs_pkg::TW_INIT_MUL * (p ^ (p >> 30)) + 32'(k);
        end
        word_idx = DEPTH;
    endfunction

    function automatic void regen_words();
        logic [31:0] y;
        logic [31:0] v;
        for (int k = 0; k < DEPTH; k++)
        begin
            y = (words[k] & mtbs_pkg::TW_UPPER) |
                (words[(k + 1) % DEPTH] & mtbs_pkg::TW_LOWER);
            v = words[(k + FAR) % DEPTH] ^ (y >> 1);
            if (y[0])
            begin
                v = v ^ mtbs_pkg::TW_MATRIX;
            end
            words[k] = v;
        end
        word_idx = 0;
    endfunction

    function automatic logic next_low_bit();
        logic [31:0] y;
        if (word_idx >= DEPTH)
        begin
            regen_words();
        end
        y = words[word_idx];
        word_idx++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & mtbs_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtbs_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y[0];
    endfunction

    function automatic logic [BYTE_W-1:0] draw_byte();
        logic [BYTE_W-1:0] acc;
        logic              b;
        acc = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            b = next_low_bit();
            acc = {acc[BYTE_W-2:0], b};
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        byte_verdict_t want;
        byte_verdict_t got;
        if (!rst_n)
        begin
            seed_words(mtbs_pkg::TW_DEFAULT_SEED);
            still_matched = 1'b1;
            errs = 0;
            bytes_due.delete();
            coming_byte <= draw_byte();
            awaiting <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got.gen = generated_byte;
                got.hit = byte_matches;
                got.run_hit = all_matched;
                if (bytes_due.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                    begin
                        $display("%0t: unexpected beat: byte %02h match %0b all %0b",
                                 $time, got.gen, got.hit, got.run_hit);
                    end
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (got != want)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("%0t: bad result: want byte %02h match %0b all %0b",
                                     $time, want.gen, want.hit, want.run_hit);
                            $display("%0t: bad result: got  byte %02h match %0b all %0b",
                                     $time, got.gen, got.hit, got.run_hit);
                        end
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (command == mtbs_tb_pkg::CMD_RESEED)
                begin
                    seed_words(seed_value);
                    still_matched = 1'b1;
                end
                else
                begin
                    want.gen = coming_byte;
                    want.hit = (coming_byte == target_byte);
                    still_matched = still_matched & want.hit;
                    want.run_hit = final_byte ? still_matched : 1'b0;
                    bytes_due.push_back(want);
                end
                coming_byte <= draw_byte();
            end
            awaiting <= bytes_due.size();
            fail_count <= errs;
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// testbench top: drives command beats, stalls result beats and reports the verdict
module tb;

    localparam int unsigned BYTE_W = mtbs_pkg::BYTE_W;

    typedef enum int
    {
        HOLD_NONE,
        HOLD_LIGHT,
        HOLD_HEAVY,
        HOLD_PATTERN
    } hold_kind_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    logic              command = mtbs_tb_pkg::CMD_RESEED;
    logic [31:0]       seed_value = '0;
    logic [BYTE_W-1:0] target_byte = '0;
    logic              final_byte = 1'b0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [BYTE_W-1:0] generated_byte;
    logic              byte_matches;
    logic              all_matched;

    logic [BYTE_W-1:0] coming_byte;
    int                awaiting;
    int                fail_count;

    int unsigned burst_left = 0;
    int unsigned sent = 0;
    int unsigned hold_left = 0;
    int unsigned tick = 0;
    hold_kind_t  hold_kind = HOLD_NONE;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mt19937_bit_stream_matcher u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .seed_value     (seed_value),
        .target_byte    (target_byte),
        .final_byte     (final_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .generated_byte (generated_byte),
        .byte_matches   (byte_matches),
        .all_matched    (all_matched)
    );

    mtbs_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .seed_value     (seed_value),
        .target_byte    (target_byte),
        .final_byte     (final_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .generated_byte (generated_byte),
        .byte_matches   (byte_matches),
        .all_matched    (all_matched),
        .coming_byte    (coming_byte),
        .awaiting       (awaiting),
        .fail_count     (fail_count)
    );

    always @(posedge clk)
    begin
        if (hold_left == 0)
        begin
            hold_kind = hold_kind_t'($urandom_range(0, 3));
            hold_left = $urandom_range(20, 200);
        end
        hold_left--;
        tick++;
        case (hold_kind)
            HOLD_NONE:  res_stall <= 1'b0;
            HOLD_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
            HOLD_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
            default:    res_stall <= tick[2] ^ tick[4];
        endcase
    end

    // aim: target is the predicted byte xor tgt, so tgt acts as an error mask
    task automatic send_beat(input mtbs_tb_pkg::mtbs_cmd_t cmd,
                             input logic [31:0] seed,
                             input logic [BYTE_W-1:0] tgt,
                             input bit aim, input bit fin);
        int unsigned pause;
        if (burst_left > 0)
        begin
            burst_left--;
            pause = 0;
        end
        else
        begin
            pause = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40)
                                                : $urandom_range(1, 10);
            burst_left = $urandom_range(0, 12);
        end
        if (aim && pause == 0)
        begin
            pause = 1;
        end
        if (pause > 0 && cmd_valid)
        begin
            cmd_valid <= 1'b0;
        end
        repeat (pause) @(posedge clk);
        command <= cmd;
        seed_value <= seed;
        target_byte <= aim ? (coming_byte ^ tgt) : tgt;
        final_byte <= fin;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        sent++;
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
    endtask

    task automatic send_stream();
        int unsigned n;
        logic [31:0] s;
        bit          fin;
        logic [BYTE_W-1:0] flip;
        if ($urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 7))
                0:       s = '0;
                1:       s = '1;
                default: s = $urandom();
            endcase
            send_beat(mtbs_tb_pkg::CMD_RESEED, s, BYTE_W'($urandom()), 1'b0,
                      1'($urandom()));
        end
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(80, 100) : $urandom_range(1, 10);
        for (int unsigned i = 0; i < n; i++)
        begin
            flip = ($urandom_range(0, 15) == 0) ? BYTE_W'(1 << $urandom_range(0, 7)) : '0;
            fin = (i == n - 1) || ($urandom_range(0, 19) == 0);
            send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, $urandom(), flip, 1'b1, fin);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // default seed after reset, a clean run
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b1);
        // fixed targets at the extremes
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b0, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b1);
        // flag stays sticky past a final byte
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b1);
        // reseed ignores target and final
        send_beat(mtbs_tb_pkg::CMD_RESEED, 32'h0, 8'hFF, 1'b0, 1'b1);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b1);
        send_beat(mtbs_tb_pkg::CMD_RESEED, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b1);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b1);
        send_beat(mtbs_tb_pkg::CMD_RESEED, mtbs_pkg::TW_DEFAULT_SEED, 8'h00, 1'b0, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b1);
        // one wrong byte in the middle of a run
        send_beat(mtbs_tb_pkg::CMD_RESEED, 32'h8000_0000, 8'h00, 1'b0, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h01, 1'b1, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b1);
        send_beat(mtbs_tb_pkg::CMD_RESEED, 32'h1, 8'h00, 1'b0, 1'b0);
        send_beat(mtbs_tb_pkg::CMD_NEXT_BYTE, 32'h0, 8'h00, 1'b1, 1'b1);
        drain_results();

        while (sent < 720)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_stream();
            end
            else
            begin
                send_beat(($urandom_range(0, 3) != 0) ? mtbs_tb_pkg::CMD_NEXT_BYTE
                                                      : mtbs_tb_pkg::CMD_RESEED,
                          $urandom(), BYTE_W'($urandom()), 1'b0, 1'($urandom()));
            end
            if ($urandom_range(0, 15) == 0)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && awaiting == 0)
        begin
            $display("mt19937_bit_stream_matcher: match");
        end
        else
        begin
            $display("mt19937_bit_stream_matcher: mismatch");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("mt19937_bit_stream_matcher: mismatch");
        $finish;
    end

endmodule
